/* rtl/tss_pkg.sv */
// Package for the three-sum search block: sizes, widths and shared types.
// No dependencies; used by every module under rtl.
`timescale 1ns / 1ps
`default_nettype none
package tss_pkg;
   localparam int MAX_ELEMENTS_DEF = 64;
   localparam int VALUE_W          = 16;
   localparam int TARGET_W         = 18;
   localparam int SUM_W            = 18;

   typedef struct packed {
      logic             found;
      logic [VALUE_W-1:0] v0;
      logic [VALUE_W-1:0] v1;
      logic [VALUE_W-1:0] v2;
   } result_type;
endpackage
`default_nettype wire

/* rtl/tss_mem.sv */
// Value store for the three-sum search: one write port, one registered read port.
// Depends on tss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tss_mem
   import tss_pkg::*;
#(
   parameter int DEPTH = MAX_ELEMENTS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [VALUE_W-1:0]       wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [VALUE_W-1:0]       rd_data
);
   logic [VALUE_W-1:0] mem_ff [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* rtl/three_sum_search_top.sv */
// Top level of the three-sum search: load, insertion sort and two-pointer scan.
// Depends on tss_pkg and tss_mem.
//
//   port group | dir | contents
//   req_*      | in  | element_value, last_element; valid/stall
//   rsp_*      | out | found, first/second/third_value; valid/stall
//   csr_*      | in  | target_sum write, no read-back
//
// Each element is stored at its transfer while the store has room. A marked element
// also starts a sort and a scan that share the single store read port: the insertion
// sort steps S_SKEY, S_SKEYW, S_SCMP, S_SCMPW per key and S_SCMP, S_SCMPW per shift,
// O(n^2); the scan steps S_I, S_R0, S_R1, S_R2, S_EVAL per pointer step (three reads
// and a compare), O(n^2); S_SDONE lies between the two and S_OUT posts the result.
// Reset clears control state only. req_stall stays high from the marked transfer
// until the result is taken; the result register holds while rsp_stall is high.
`timescale 1ns / 1ps
`default_nettype none
module three_sum_search_top
   import tss_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_stall,
   input  wire logic signed [VALUE_W-1:0]  req_element_value,
   input  wire logic                       req_last_element,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      logic                       rsp_found,
   output      logic signed [VALUE_W-1:0]  rsp_first_value,
   output      logic signed [VALUE_W-1:0]  rsp_second_value,
   output      logic signed [VALUE_W-1:0]  rsp_third_value,
   input  wire logic                       csr_write,
   input  wire logic signed [TARGET_W-1:0] csr_target_sum
);
   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int CW = $clog2(MAX_ELEMENTS + 1);

   typedef enum logic [3:0] {
      S_LOAD, S_SKEY, S_SKEYW, S_SCMP, S_SCMPW, S_SDONE,
      S_I, S_R0, S_R1, S_R2, S_EVAL, S_OUT
   } state_type;

   state_type state_ff;
   logic [CW-1:0] count_ff;
   logic [AW-1:0] a_ff, b_ff, i_ff, l_ff, r_ff;
   logic signed [VALUE_W-1:0] key_ff, x0_ff, x1_ff, x2_ff;
   logic signed [TARGET_W-1:0] target_ff;
   result_type res_ff;
   logic rsp_valid_ff;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [VALUE_W-1:0] wr_data, rd_data;
   logic signed [SUM_W-1:0] sum;
   logic req_take;

   assign req_stall = (state_ff != S_LOAD) || rsp_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign sum = SUM_W'(x0_ff) + SUM_W'(x1_ff) + SUM_W'(x2_ff);

   // Store port: load writes, sort shifts and key placement write.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = b_ff;
      wr_data = rd_data;
      rd_addr = a_ff;
      case (state_ff)
         S_LOAD: begin
            wr_en   = req_take && (count_ff < CW'(MAX_ELEMENTS));
            wr_addr = count_ff[AW-1:0];
            wr_data = req_element_value;
         end
         S_SKEY:  rd_addr = a_ff;
         S_SCMP:  rd_addr = b_ff - AW'(1);
         S_SCMPW: begin
            // shift larger predecessor up, or drop the key in place
            wr_en   = 1'b1;
            wr_addr = b_ff;
            wr_data = ((b_ff != '0) && ($signed(rd_data) > key_ff)) ? rd_data : key_ff;
         end
         S_I:     rd_addr = i_ff;
         S_R0:    rd_addr = l_ff;
         S_R1:    rd_addr = r_ff;
         default: rd_addr = a_ff;
      endcase
   end

   tss_mem #(.DEPTH(MAX_ELEMENTS)) u_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         target_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            target_ff <= csr_target_sum;
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_LOAD: begin
               if (req_take) begin
                  if (count_ff < CW'(MAX_ELEMENTS)) begin
                     count_ff <= count_ff + CW'(1);
                  end
                  if (req_last_element) begin
                     a_ff     <= AW'(1);
                     state_ff <= S_SKEY;
                  end
               end
            end
            S_SKEY: begin
               // the set size is count_ff (+1 if the mark was stored, already counted)
               if (CW'(a_ff) >= count_ff || a_ff == '0) begin
                  state_ff <= S_SDONE;
               end else begin
                  b_ff     <= a_ff;
                  state_ff <= S_SKEYW;
               end
            end
            S_SKEYW: begin
               key_ff   <= rd_data;
               state_ff <= S_SCMP;
            end
            S_SCMP: state_ff <= S_SCMPW;
            S_SCMPW: begin
               if ((b_ff != '0) && ($signed(rd_data) > key_ff)) begin
                  b_ff     <= b_ff - AW'(1);
                  state_ff <= S_SCMP;
               end else begin
                  a_ff     <= a_ff + AW'(1);
                  state_ff <= (CW'(a_ff) + CW'(1) >= count_ff) ? S_SDONE : S_SKEY;
               end
            end
            S_SDONE: begin
               i_ff        <= '0;
               l_ff        <= AW'(1);
               r_ff        <= AW'(count_ff - CW'(1));
               res_ff      <= '0;
               state_ff    <= (count_ff < CW'(3)) ? S_OUT : S_I;
            end
            S_I:  state_ff <= S_R0;
            S_R0: begin
               x0_ff    <= rd_data;
               state_ff <= S_R1;
            end
            S_R1: begin
               x1_ff    <= rd_data;
               state_ff <= S_R2;
            end
            S_R2: begin
               x2_ff    <= rd_data;
               state_ff <= S_EVAL;
            end
            S_EVAL: begin
               if (sum == target_ff) begin
                  res_ff   <= '{1'b1, x0_ff, x1_ff, x2_ff};
                  state_ff <= S_OUT;
               end else if (l_ff + AW'(1) == r_ff) begin
                  // pointers meet: advance first index and restart pointers, or finish
                  if (CW'(i_ff) + CW'(3) >= count_ff) begin
                     state_ff <= S_OUT;
                  end else begin
                     i_ff     <= i_ff + AW'(1);
                     l_ff     <= i_ff + AW'(2);
                     r_ff     <= AW'(count_ff - CW'(1));
                     state_ff <= S_I;
                  end
               end else begin
                  if (sum < target_ff) begin
                     l_ff <= l_ff + AW'(1);
                  end else begin
                     r_ff <= r_ff - AW'(1);
                  end
                  state_ff <= S_I;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  count_ff     <= '0;
                  state_ff     <= S_LOAD;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = res_ff.found;
   assign rsp_first_value  = res_ff.v0;
   assign rsp_second_value = res_ff.v1;
   assign rsp_third_value  = res_ff.v2;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ELEMENTS))
      else $error("fill count above depth");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LOAD) |-> !req_take)
      else $error("input taken during search");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(res_ff)))
      else $error("result changed while stalled");
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !res_ff.found) |-> (res_ff.v0 == '0 && res_ff.v1 == '0))
      else $error("not-found result carries values");
endmodule
`default_nettype wire

/* dv/tb.sv */
// Testbench for three_sum_search_top: directed and random sets against a local triplet predictor.
// Depends on tss_pkg and the RTL under rtl.
`timescale 1ns / 1ps
module tb;
   import tss_pkg::*;

   localparam int DEPTH = MAX_ELEMENTS_DEF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [VALUE_W-1:0] req_element_value = '0;
   logic req_last_element = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_found;
   logic signed [VALUE_W-1:0] rsp_first_value, rsp_second_value, rsp_third_value;
   logic csr_write = 1'b0;
   logic signed [TARGET_W-1:0] csr_target_sum = '0;

   three_sum_search_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_element_value(req_element_value), .req_last_element(req_last_element),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_found(rsp_found), .rsp_first_value(rsp_first_value),
      .rsp_second_value(rsp_second_value), .rsp_third_value(rsp_third_value),
      .csr_write(csr_write), .csr_target_sum(csr_target_sum)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state: the target and the set being loaded.
   int target_q;
   int set_vals[DEPTH];
   int set_count;
   result_type triplet_q[$];
   int errors = 0;
   bit calm = 1'b0;   // when set, neither side idles

   // Sort the held set and run the two-pointer scan; queue the triplet.
   task automatic predict_triplet();
      int a, b, key, i, l, r, s;
      result_type res;
      res = '0;
      for (a = 1; a < set_count; a++) begin
         key = set_vals[a];
         b = a;
         while (b > 0 && set_vals[b-1] > key) begin
            set_vals[b] = set_vals[b-1];
            b--;
         end
         set_vals[b] = key;
      end
      for (i = 0; !res.found && i + 2 < set_count; i++) begin
         l = i + 1;
         r = set_count - 1;
         while (l < r) begin
            s = set_vals[i] + set_vals[l] + set_vals[r];
            if (s == target_q) begin
               res.found = 1'b1;
               res.v0 = set_vals[i][15:0];
               res.v1 = set_vals[l][15:0];
               res.v2 = set_vals[r][15:0];
               break;
            end else if (s < target_q) begin
               l++;
            end else begin
               r--;
            end
         end
      end
      set_count = 0;
      triplet_q.push_back(res);
   endtask

   // Send one element; hold it until the transfer, then update the predictor.
   // Valid stays high on return; an idle gap in the next send or an explicit drop clears it.
   task automatic send_element(input logic signed [15:0] v, input bit last);
      while (!calm && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_element_value <= v;
      req_last_element <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (set_count < DEPTH) begin
         set_vals[set_count] = v;
         set_count++;
      end
      if (last) predict_triplet();
      @(negedge clock);
   endtask

   // Drop valid, drain outstanding results, then write the target while idle.
   task automatic write_target(input int t);
      req_valid <= 1'b0;
      while (triplet_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_write <= 1'b1;
      csr_target_sum <= t[17:0];
      @(negedge clock);
      csr_write <= 1'b0;
      target_q = t;
   endtask

   task automatic send_set(input int n, input int span);
      int k;
      for (k = 0; k < n; k++)
         send_element($signed(16'($urandom_range(2*span) - span)), k == n - 1);
   endtask

   // Extremes, small sets, store overflow and a marked value past full.
   task automatic test_directed();
      int k;
      write_target(0);
      send_element(16'sd5, 1'b1);
      send_element(16'sd1, 1'b0);
      send_element(-16'sd1, 1'b1);
      send_element(-16'sd4, 1'b0);
      send_element(16'sd1, 1'b0);
      send_element(16'sd3, 1'b1);
      write_target(98301);
      send_element(16'sd32767, 1'b0);
      send_element(16'sd32767, 1'b0);
      send_element(16'sd32767, 1'b1);
      write_target(-98304);
      send_element(-16'sd32768, 1'b0);
      send_element(-16'sd32768, 1'b0);
      send_element(16'sd7, 1'b0);
      send_element(-16'sd32768, 1'b1);
      write_target(3);
      for (k = 0; k < DEPTH + 3; k++)
         send_element(16'(k % 5), k == DEPTH + 2);
   endtask

   // Mostly small sets with small values so triplets are common.
   task automatic test_random();
      int sent;
      int n;
      sent = 0;
      while (sent < 1600) begin
         if ($urandom_range(9) == 0) write_target($urandom_range(60) - 30);
         calm = (sent > 600 && sent < 800);
         n = ($urandom_range(19) == 0) ? $urandom_range(DEPTH + 4, 3)
                                      : $urandom_range(12, 1);
         if ($urandom_range(4) == 0) send_set(n, 32767);
         else send_set(n, 12);
         sent += n;
      end
      calm = 1'b0;
      write_target($urandom_range(196605) - 98304);
      send_set(20, 32767);
   endtask

   // Result side: random stall, compare each transfer with the oldest triplet.
   always @(negedge clock)
      rsp_stall <= !calm && ($urandom_range(99) < 18);

   always @(posedge clock) begin
      result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (triplet_q.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
         end else begin
            exp_r = triplet_q.pop_front();
            if (rsp_found !== exp_r.found) begin
               $error("found: expected %0d actual %0d", exp_r.found, rsp_found);
               errors++;
            end
            if (rsp_first_value !== exp_r.v0) begin
               $error("first_value: expected %0d actual %0d",
                      $signed(exp_r.v0), rsp_first_value);
               errors++;
            end
            if (rsp_second_value !== exp_r.v1) begin
               $error("second_value: expected %0d actual %0d",
                      $signed(exp_r.v1), rsp_second_value);
               errors++;
            end
            if (rsp_third_value !== exp_r.v2) begin
               $error("third_value: expected %0d actual %0d",
                      $signed(exp_r.v2), rsp_third_value);
               errors++;
            end
         end
      end
   end

   initial begin
      target_q = 0;
      set_count = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random();
      req_valid <= 1'b0;
      while (triplet_q.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (errors == 0 && triplet_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Timeout: far beyond the slowest legal run.
   initial begin
      #60ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
